[design/mwrd_pkg.sv]
// ----------------------------------------------------------------------------
// mwrd_pkg
// shared types and constants of the microwire eeprom read master
// ----------------------------------------------------------------------------
package mwrd_pkg;

    localparam int ADDR_W = 8;    // width of the word address field
    localparam int WORD_W = 16;   // width of the read word field

    localparam int ADDRESS_BITS_DEF = 8;
    localparam int DATA_BITS_DEF    = 16;

    // fixed part of the slot sequence
    localparam int SLOT_ENABLE = 1;   // enable rises from here on
    localparam int SLOT_SELECT = 2;   // chip select rises from here on
    localparam int SLOT_OPCODE = 3;   // first opcode bit
    localparam int SLOT_ADDR   = 6;   // first address bit

    // read opcode, sent msb first
    localparam logic [2:0] READ_OPCODE = 3'b110;

    typedef struct packed {
        logic              start_req;
        logic [ADDR_W-1:0] word_address;
        logic              serial_in;
    } t_item;

    typedef struct packed {
        logic              clock_pulse;
        logic              interface_enable;
        logic              chip_select;
        logic              serial_out;
        logic              busy_res;
        logic              word_valid;
        logic [WORD_W-1:0] read_word;
    } t_result;

    typedef struct packed {
        logic active;
        logic final_slot;
    } t_seq_status;

endpackage

[design/mwrd_seq.sv]
// ----------------------------------------------------------------------------
// mwrd_seq
// slot sequencer: decodes one bit slot and advances the read sequence
// ----------------------------------------------------------------------------
module mwrd_seq #(
    parameter int ADDRESS_BITS = mwrd_pkg::ADDRESS_BITS_DEF,
    parameter int DATA_BITS    = mwrd_pkg::DATA_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  mwrd_pkg::t_item       i_item,
    output mwrd_pkg::t_result     o_result,
    output mwrd_pkg::t_seq_status o_status
);

    localparam int SLOT_DUMMY = mwrd_pkg::SLOT_ADDR + ADDRESS_BITS;
    localparam int SLOT_DATA  = SLOT_DUMMY + 1;
    localparam int SLOT_DESEL = SLOT_DATA + DATA_BITS;
    localparam int SLOT_FINAL = SLOT_DESEL + 1;
    localparam int SLOT_W     = $clog2(SLOT_FINAL + 1);

    logic                    r_active;
    logic [SLOT_W-1:0]       r_slot;
    logic [ADDRESS_BITS-1:0] r_addr_sh;
    logic [DATA_BITS-1:0]    r_shift;

    logic                    n_active;
    logic [SLOT_W-1:0]       n_slot;
    logic [ADDRESS_BITS-1:0] n_addr_sh;
    logic [DATA_BITS-1:0]    n_shift;

    logic                    run;
    logic [SLOT_W-1:0]       slot;
    logic [ADDRESS_BITS-1:0] addr_sh;
    logic [DATA_BITS-1:0]    shift;
    logic [1:0]              op_idx;

    always_comb begin
        // a start while idle begins the sequence in this same slot
        run     = r_active | i_item.start_req;
        slot    = r_active ? r_slot : '0;
        addr_sh = r_active ? r_addr_sh : ADDRESS_BITS'(i_item.word_address);
        shift   = r_active ? r_shift : '0;
        op_idx  = 2'(SLOT_W'(mwrd_pkg::SLOT_ADDR - 1) - slot);

        o_result  = '0;
        n_active  = r_active;
        n_slot    = r_slot;
        n_addr_sh = r_addr_sh;
        n_shift   = r_shift;

        if (run) begin
            n_addr_sh = addr_sh;
            n_shift   = shift;
            if (slot >= SLOT_W'(SLOT_FINAL)) begin
                o_result.word_valid = 1'b1;
                o_result.read_word  = mwrd_pkg::WORD_W'(shift);
                n_active            = 1'b0;
                n_slot              = '0;
            end else begin
                o_result.clock_pulse      = 1'b1;
                o_result.busy_res         = 1'b1;
                o_result.interface_enable = (slot >= SLOT_W'(mwrd_pkg::SLOT_ENABLE));
                o_result.chip_select      = (slot >= SLOT_W'(mwrd_pkg::SLOT_SELECT)) &&
                                            (slot <  SLOT_W'(SLOT_DESEL));
                if (slot >= SLOT_W'(mwrd_pkg::SLOT_OPCODE) &&
                    slot <  SLOT_W'(mwrd_pkg::SLOT_ADDR)) begin
                    o_result.serial_out = mwrd_pkg::READ_OPCODE[op_idx];
                end else if (slot >= SLOT_W'(mwrd_pkg::SLOT_ADDR) &&
                             slot <  SLOT_W'(SLOT_DUMMY)) begin
                    o_result.serial_out = addr_sh[ADDRESS_BITS-1];
                    n_addr_sh           = addr_sh << 1;
                end else if (slot >= SLOT_W'(SLOT_DATA) &&
                             slot <  SLOT_W'(SLOT_DESEL)) begin
                    n_shift = {shift[DATA_BITS-2:0], i_item.serial_in};
                end
                n_active = 1'b1;
                n_slot   = slot + SLOT_W'(1);
            end
        end
    end

    always_comb begin
        o_status.active     = r_active;
        o_status.final_slot = r_active && (r_slot >= SLOT_W'(SLOT_FINAL));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_slot   <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_slot   <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_addr_sh <= n_addr_sh;
            r_shift   <= n_shift;
        end
    end

endmodule

[design/microwire_eeprom_read_master_top.sv]
// ----------------------------------------------------------------------------
// microwire_eeprom_read_master_top
// microwire eeprom word read master, one serial bit slot per transfer
// ----------------------------------------------------------------------------
// Each input transfer is one serial bit slot and yields exactly one output
// transfer describing that slot. A start request while idle latches the word
// address and begins the read at once; a read takes ADDRESS_BITS + DATA_BITS
// + 8 clocked slots (idle, enable, select, opcode 110, address msb first,
// dummy zero, data bits sampled msb first, deselect) plus one unclocked slot
// that drops the enable and shows the word with word_valid. Starts that
// arrive during a read, its final slot included, are ignored. The block
// takes one transfer per clock while its input is not stalled; a slot goes
// from the input register through the slot decoder into the result
// register, so back-to-back slots flow at one per clock while the output
// is not stalled. While a finished result waits, the input register can
// take one more transfer; after that the input stalls until the result is
// taken.
// ----------------------------------------------------------------------------
module microwire_eeprom_read_master_top #(
    parameter int ADDRESS_BITS = mwrd_pkg::ADDRESS_BITS_DEF,
    parameter int DATA_BITS    = mwrd_pkg::DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_start_req,
    input  logic [mwrd_pkg::ADDR_W-1:0] i_word_address,
    input  logic                        i_serial_in,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_clock_pulse,
    output logic                        o_interface_enable,
    output logic                        o_chip_select,
    output logic                        o_serial_out,
    output logic                        o_busy_res,
    output logic                        o_word_valid,
    output logic [mwrd_pkg::WORD_W-1:0] o_read_word
);

    // input register
    logic                  r_in_valid;
    mwrd_pkg::t_item       r_in;
    // result register
    logic                  r_out_valid;
    mwrd_pkg::t_result     r_out;

    logic                  advance;
    mwrd_pkg::t_result     seq_res;
    mwrd_pkg::t_seq_status seq_status;

    // a held slot moves on when the result register is empty or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in.start_req    <= i_start_req;
            r_in.word_address <= i_word_address;
            r_in.serial_in    <= i_serial_in;
        end
    end

    // slot decode and sequence state, stepped once per moved slot
    mwrd_seq #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .DATA_BITS    (DATA_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (seq_res),
        .o_status (seq_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_clock_pulse      = r_out.clock_pulse;
    assign o_interface_enable = r_out.interface_enable;
    assign o_chip_select      = r_out.chip_select;
    assign o_serial_out       = r_out.serial_out;
    assign o_busy_res         = r_out.busy_res;
    assign o_word_valid       = r_out.word_valid;
    assign o_read_word        = r_out.read_word;

    // every clocked slot leaves the sequence running
    a_busy_keeps_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && seq_res.busy_res |=> seq_status.active)
        else $error("sequence stopped after a clocked slot");

    // the final slot ends the sequence
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && seq_res.word_valid |=> !seq_status.active)
        else $error("sequence still running after the final slot");

    // the final slot always presents the word
    a_final_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && seq_status.final_slot |-> seq_res.word_valid && !seq_res.clock_pulse)
        else $error("final slot without word_valid");

    // chip select never active without the interface enable
    a_cs_needs_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.chip_select |-> r_out.interface_enable)
        else $error("chip select without interface enable");

endmodule

[tb/sv/mwrd_slot_checker.sv]
// ----------------------------------------------------------------------------
// mwrd_slot_checker
// predicts each serial bit slot of the read master and checks the results
// ----------------------------------------------------------------------------
// Every input transfer is run through a slot sequencer of its own. The
// sequencer gives the expected result, which is queued. Each output transfer
// is compared, field by field, with the oldest queued result.
// ----------------------------------------------------------------------------
module mwrd_slot_checker #(
    parameter int ADDRESS_BITS = mwrd_pkg::ADDRESS_BITS_DEF,
    parameter int DATA_BITS    = mwrd_pkg::DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_start_req,
    input  logic [mwrd_pkg::ADDR_W-1:0] i_word_address,
    input  logic                        i_serial_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_clock_pulse,
    input  logic                        i_interface_enable,
    input  logic                        i_chip_select,
    input  logic                        i_serial_out,
    input  logic                        i_busy_res,
    input  logic                        i_word_valid,
    input  logic [mwrd_pkg::WORD_W-1:0] i_read_word,
    output int                          o_mismatch_count,
    output int                          o_slots_pending
);

    localparam int SLOT_DUMMY = mwrd_pkg::SLOT_ADDR + ADDRESS_BITS;
    localparam int SLOT_DATA  = SLOT_DUMMY + 1;
    localparam int SLOT_DESEL = SLOT_DATA + DATA_BITS;
    localparam int SLOT_FINAL = SLOT_DESEL + 1;

    // sequencer state
    int unsigned          slot_idx;
    logic                 seq_active;
    int unsigned          addr_latch;
    logic [DATA_BITS-1:0] data_shift;

    mwrd_pkg::t_result expected_slots[$];

    function automatic mwrd_pkg::t_result next_slot(mwrd_pkg::t_item it);
        mwrd_pkg::t_result r;
        int unsigned       s;
        r = '0;
        if (!seq_active && it.start_req) begin
            seq_active = 1'b1;
            slot_idx   = 0;
            addr_latch = it.word_address;
            data_shift = '0;
        end
        if (seq_active) begin
            s = slot_idx;
            if (s >= SLOT_FINAL) begin
                r.word_valid = 1'b1;
                r.read_word  = mwrd_pkg::WORD_W'(data_shift);
                seq_active   = 1'b0;
                slot_idx     = 0;
            end else begin
                r.clock_pulse      = 1'b1;
                r.busy_res         = 1'b1;
                r.interface_enable = (s >= mwrd_pkg::SLOT_ENABLE);
                r.chip_select      = (s >= mwrd_pkg::SLOT_SELECT) && (s < SLOT_DESEL);
                if (s >= mwrd_pkg::SLOT_OPCODE && s < mwrd_pkg::SLOT_ADDR) begin
                    r.serial_out = mwrd_pkg::READ_OPCODE[2 - (s - mwrd_pkg::SLOT_OPCODE)];
                end else if (s >= mwrd_pkg::SLOT_ADDR && s < SLOT_DUMMY) begin
                    // address bits above the field width go out as zero
                    r.serial_out = 1'((addr_latch >>
                                       (ADDRESS_BITS - 1 - (s - mwrd_pkg::SLOT_ADDR))) & 1);
                end else if (s >= SLOT_DATA && s < SLOT_DESEL) begin
                    data_shift = {data_shift[DATA_BITS-2:0], it.serial_in};
                end
                slot_idx = s + 1;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
            o_mismatch_count++;
        end
    endfunction

    initial begin
        o_mismatch_count = 0;
        o_slots_pending  = 0;
    end

    always @(posedge i_clk) begin : watch
        mwrd_pkg::t_item   it;
        mwrd_pkg::t_result want;
        if (!i_rst_n) begin
            slot_idx   = 0;
            seq_active = 1'b0;
            addr_latch = 0;
            data_shift = '0;
            expected_slots.delete();
        end else begin
            // results first, so a result can never meet its own input
            if (i_out_valid && !i_out_stall) begin
                if (expected_slots.size() == 0) begin
                    $display("%0t: result with none expected, actual word %0h valid %0b",
                             $time, i_read_word, i_word_valid);
                    o_mismatch_count++;
                end else begin
                    want = expected_slots.pop_front();
                    check_field("clock_pulse", want.clock_pulse, i_clock_pulse);
                    check_field("interface_enable", want.interface_enable,
                                i_interface_enable);
                    check_field("chip_select", want.chip_select, i_chip_select);
                    check_field("serial_out", want.serial_out, i_serial_out);
                    check_field("busy_res", want.busy_res, i_busy_res);
                    check_field("word_valid", want.word_valid, i_word_valid);
                    check_field("read_word", want.read_word, i_read_word);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                it.start_req    = i_start_req;
                it.word_address = i_word_address;
                it.serial_in    = i_serial_in;
                expected_slots.push_back(next_slot(it));
            end
        end
        o_slots_pending <= expected_slots.size();
    end

endmodule

[tb/sv/tb_microwire_eeprom_read_master_top.sv]
// ----------------------------------------------------------------------------
// tb_microwire_eeprom_read_master_top
// random and directed test of the microwire eeprom read master
// ----------------------------------------------------------------------------
// Drives bit slots into the block: whole read sequences with random address
// and data-in levels, starts sprinkled through busy slots, and loose noise
// slots that break sequences. Both channels idle at random. A separate
// checker predicts every slot and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_microwire_eeprom_read_master_top;

    localparam int READ_LEN    = mwrd_pkg::SLOT_ADDR + mwrd_pkg::ADDRESS_BITS_DEF
                                 + mwrd_pkg::DATA_BITS_DEF + 3;
    localparam int ITEM_TARGET = 1100;
    localparam int HOLD_CYCLES = 200;   // one long receiver hold-off
    localparam int IDLE_LIMIT  = 3000;  // cycles without any transfer
    localparam int DRAIN_WAIT  = 16;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        start_req;
    logic [mwrd_pkg::ADDR_W-1:0] word_address;
    logic                        serial_in;
    logic                        out_stall;

    logic                        in_stall;
    logic                        out_valid;
    logic                        clock_pulse;
    logic                        interface_enable;
    logic                        chip_select;
    logic                        serial_out;
    logic                        busy_res;
    logic                        word_valid;
    logic [mwrd_pkg::WORD_W-1:0] read_word;

    int mismatch_count;
    int slots_pending;
    int slots_sent;
    bit sender_calm;

    microwire_eeprom_read_master_top dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_start_req        (start_req),
        .i_word_address     (word_address),
        .i_serial_in        (serial_in),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_clock_pulse      (clock_pulse),
        .o_interface_enable (interface_enable),
        .o_chip_select      (chip_select),
        .o_serial_out       (serial_out),
        .o_busy_res         (busy_res),
        .o_word_valid       (word_valid),
        .o_read_word        (read_word)
    );

    mwrd_slot_checker checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_start_req        (start_req),
        .i_word_address     (word_address),
        .i_serial_in        (serial_in),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_clock_pulse      (clock_pulse),
        .i_interface_enable (interface_enable),
        .i_chip_select      (chip_select),
        .i_serial_out       (serial_out),
        .i_busy_res         (busy_res),
        .i_word_valid       (word_valid),
        .i_read_word        (read_word),
        .o_mismatch_count   (mismatch_count),
        .o_slots_pending    (slots_pending)
    );

    // clock, period 8
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // reset applied once, at the start of the run
    initial begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender gap after a transfer: mostly none, some short, a few long ones
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one bit slot and hold it until the block takes the transfer
    task automatic send_slot(input logic st, input logic [mwrd_pkg::ADDR_W-1:0] addr,
                             input logic sin);
        int gap;
        in_valid     <= 1'b1;
        start_req    <= st;
        word_address <= addr;
        serial_in    <= sin;
        do @(posedge clk); while (in_stall);
        slots_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender stops until every predicted slot has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (slots_pending != 0);
    endtask

    // one well-formed read: start slot, then the rest of the sequence with
    // random data-in and the odd start that the busy block must ignore
    task automatic read_word_seq(input logic [mwrd_pkg::ADDR_W-1:0] addr,
                                 input int start_odds);
        send_slot(1'b1, addr, 1'($urandom));
        repeat (READ_LEN - 1)
            send_slot(($urandom_range(0, 99) < start_odds),
                      mwrd_pkg::ADDR_W'($urandom), 1'($urandom));
    endtask

    // stimulus
    initial begin : stimulus
        int  noise_len;
        bit  paused;
        in_valid     <= 1'b0;
        start_req    <= 1'b0;
        word_address <= '0;
        serial_in    <= 1'b0;
        slots_sent   = 0;
        sender_calm  = 1'b1;
        paused       = 1'b0;
        do @(posedge clk); while (!rst_n);

        // directed: idle slots with busy fields set, read at the top address
        // with data-in all ones and a start in every slot, the final one too
        send_slot(1'b0, '1, 1'b1);
        send_slot(1'b0, '0, 1'b0);
        send_slot(1'b1, '1, 1'b1);
        repeat (READ_LEN - 1) send_slot(1'b1, '1, 1'b1);
        // back-to-back read at address zero with data-in all zeros
        send_slot(1'b1, '0, 1'b0);
        repeat (READ_LEN - 1) send_slot(1'b0, '1, 1'b0);
        // address A5 with alternating data-in bits
        send_slot(1'b1, 8'hA5, 1'b1);
        for (int k = 1; k < READ_LEN; k++) send_slot(1'b0, 8'h5A, 1'(k));
        drain_results();

        // random part
        while (slots_sent < ITEM_TARGET) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85) begin
                read_word_seq(mwrd_pkg::ADDR_W'($urandom), $urandom_range(0, 1) ? 0 : 15);
            end else begin
                // noise: loose slots that can start or cut into a read
                noise_len = $urandom_range(1, 12);
                repeat (noise_len)
                    send_slot(1'($urandom), mwrd_pkg::ADDR_W'($urandom), 1'($urandom));
            end
            if (!paused && slots_sent > ITEM_TARGET / 2) begin
                paused = 1'b1;
                drain_results();
            end
        end

        // wind down: wait for every result, then give the verdict
        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // receiver: stretches of no stall, short stalls and long stalls, plus
    // one long hold-off so that the block fills and stalls its input
    initial begin : receiver
        int  mode;
        int  rx_cycles;
        bit  hold_done;
        out_stall <= 1'b0;
        rx_cycles = 0;
        hold_done = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            repeat (48) begin
                if (!hold_done && rx_cycles > 700) begin
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    rx_cycles += HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                case (mode)
                    0: begin
                        out_stall <= 1'b0;
                    end
                    3: begin
                        if ($urandom_range(0, 19) == 0) begin
                            out_stall <= 1'b1;
                            repeat ($urandom_range(10, 30)) @(posedge clk);
                        end
                        out_stall <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        out_stall <= ($urandom_range(0, 2) == 0);
                    end
                endcase
                @(posedge clk);
                rx_cycles++;
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
